FILE: rtl/mfde_pkg.sv
// Shared constants and types for the monochrome framebuffer draw engine.
package mfde_pkg;

   localparam int DefWidth  = 128;
   localparam int DefHeight = 64;
   localparam int CoordBits = 8;
   localparam int OpBits    = 3;
   localparam int DataBits  = 8;

   localparam logic [OpBits-1:0] OP_PIXEL = 3'd0;
   localparam logic [OpBits-1:0] OP_LINE  = 3'd1;
   localparam logic [OpBits-1:0] OP_RECT  = 3'd2;
   localparam logic [OpBits-1:0] OP_FILL  = 3'd3;
   localparam logic [OpBits-1:0] OP_READ  = 3'd4;
   localparam logic [OpBits-1:0] OP_NOP   = 3'd7;

   typedef struct packed {
      logic [OpBits-1:0]    op;
      logic [CoordBits-1:0] x_start;
      logic [CoordBits-1:0] y_start;
      logic [CoordBits-1:0] x_end;
      logic [CoordBits-1:0] y_end;
      logic                 color;
   } cmd_type;

   typedef struct packed {
      logic [DataBits-1:0] read_data;
   } rsp_type;

endpackage

FILE: rtl/mfde_if.sv
// Valid/ready channel interfaces for commands and responses.
interface mfde_req_if;
   logic              valid;
   logic              ready;
   mfde_pkg::cmd_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mfde_rsp_if;
   logic              valid;
   logic              ready;
   mfde_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/mfde_front.sv
// Command front end: accepts items, classifies op codes and queues them.
module mfde_front (
   input  logic              clock,
   input  logic              reset,
   mfde_req_if.sink          req,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output mfde_pkg::cmd_type cmd_data
);

   localparam int Depth = 2;

   mfde_pkg::cmd_type queue_ff [Depth];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   mfde_pkg::cmd_type classified;
   logic              push, pop;

   // Unused op codes collapse to one no-op code so the back end sees few cases.
   always_comb begin
      classified = req.payload;
      if (req.payload.op > mfde_pkg::OP_READ) begin
         classified.op = mfde_pkg::OP_NOP;
      end
   end

   assign req.ready = (count_ff != 2'(Depth));
   assign push      = req.valid && req.ready;
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(Depth)) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'(Depth) |-> !push) else $error("push into full queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not advance");

endmodule

FILE: rtl/mfde_back.sv
// Drawing back end: pixel stepping, read-modify-write of the frame store.
module mfde_back #(
   parameter int Width  = mfde_pkg::DefWidth,
   parameter int Height = mfde_pkg::DefHeight
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  mfde_pkg::cmd_type cmd_data,
   mfde_rsp_if.source        rsp
);

   localparam int Pages     = (Height + 7) / 8;
   localparam int PageBits  = (Pages > 1) ? $clog2(Pages) : 1;
   localparam int Depth     = Width * Pages;
   localparam int AddrBits  = $clog2(Depth);
   localparam int CB        = mfde_pkg::CoordBits;
   localparam int EB        = CB + 3;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_PLOT  = 3'd2;
   localparam logic [2:0] ST_RMW   = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_RSP   = 3'd6;
   localparam logic [2:0] ST_LATCH = 3'd7;

   logic [mfde_pkg::DataBits-1:0] mem [Depth];
   logic [mfde_pkg::DataBits-1:0] rd_data_ff;

   logic [2:0]          state_ff, state_in;
   logic [mfde_pkg::OpBits-1:0] op_ff;
   logic                color_ff;
   logic [CB-1:0]       x_ff, y_ff, xe_ff, ye_ff, y0_ff;
   logic [CB-1:0]       x_in, y_in;
   logic                sx_ff, sy_ff;
   logic signed [EB-1:0] err_ff, err_in, dx_ff, dy_ff;
   logic signed [EB-1:0] cmd_dx, cmd_dy;
   logic                last_ff, last_in;  // line: endpoint plot pending first
   logic [AddrBits:0]   sweep_ff, sweep_in;
   logic [mfde_pkg::DataBits-1:0] out_ff;

   logic                pix_in_range;
   logic [AddrBits-1:0] pix_addr, rmw_addr_ff;
   logic [mfde_pkg::DataBits-1:0] pix_mask, mask_ff;
   logic [CB-1:0]       px, py;
   logic signed [EB-1:0] e2;
   logic                done_pixels;

   // Current pixel: for a line the endpoint is plotted first.
   assign px = (op_ff == mfde_pkg::OP_LINE && last_ff) ? xe_ff : x_ff;
   assign py = (op_ff == mfde_pkg::OP_LINE && last_ff) ? ye_ff : y_ff;
   assign pix_in_range = (32'(px) < Width) && (32'(py) < Height);
   assign pix_addr = AddrBits'(32'(px) * Pages + (Pages - 1) - 32'(py >> 3));
   assign pix_mask = 8'h80 >> py[2:0];
   assign e2 = err_ff <<< 1;

   assign cmd_dx = EB'((cmd_data.x_end > cmd_data.x_start) ?
                       cmd_data.x_end - cmd_data.x_start :
                       cmd_data.x_start - cmd_data.x_end);
   assign cmd_dy = EB'((cmd_data.y_end > cmd_data.y_start) ?
                       cmd_data.y_end - cmd_data.y_start :
                       cmd_data.y_start - cmd_data.y_end);

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      sweep_in = sweep_ff;
      done_pixels = 1'b0;
      unique case (state_ff)
         ST_CLEAR, ST_FILL: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (AddrBits+1)'(Depth - 1)) begin
               state_in = (state_ff == ST_CLEAR) ? ST_IDLE : ST_RSP;
            end
         end
         ST_PLOT: begin
            if (pix_in_range) begin
               state_in = ST_RMW;
            end else begin
               done_pixels = 1'b1;
            end
         end
         ST_RMW: begin
            done_pixels = 1'b1;
         end
         ST_READ: state_in = ST_LATCH;
         ST_LATCH: state_in = ST_RSP;
         ST_RSP: if (rsp.ready) state_in = ST_IDLE;
         default: ;
      endcase
      // Advance to the next pixel once the current one is finished.
      if (done_pixels) begin
         state_in = ST_PLOT;
         if (op_ff == mfde_pkg::OP_PIXEL) begin
            state_in = ST_RSP;
         end else if (op_ff == mfde_pkg::OP_LINE) begin
            if (last_ff) begin
               last_in = 1'b0;
            end else begin
               if (x_ff == xe_ff && y_ff == ye_ff) state_in = ST_RSP;
               if (e2 > -dy_ff) begin
                  err_in = err_in - dy_ff;
                  x_in   = sx_ff ? x_ff + 1'b1 : x_ff - 1'b1;
               end
               if (e2 < dx_ff) begin
                  err_in = err_in + dx_ff;
                  y_in   = sy_ff ? y_ff + 1'b1 : y_ff - 1'b1;
               end
               if (x_ff == xe_ff && y_ff == ye_ff) begin
                  x_in = x_ff;
                  y_in = y_ff;
               end
            end
         end else begin
            // Rectangle: column-major scan, ends already clipped.
            if (y_ff == ye_ff) begin
               y_in = y0_ff;
               x_in = x_ff + 1'b1;
               if (x_ff == xe_ff) state_in = ST_RSP;
            end else begin
               y_in = y_ff + 1'b1;
            end
         end
      end
      // A newly taken command loads the walk state and picks the first step.
      if (cmd_valid && cmd_ready) begin
         sweep_in = '0;
         x_in     = cmd_data.x_start;
         y_in     = cmd_data.y_start;
         err_in   = cmd_dx - cmd_dy;
         last_in  = (cmd_data.op == mfde_pkg::OP_LINE);
         unique case (cmd_data.op) inside
            mfde_pkg::OP_PIXEL, mfde_pkg::OP_LINE: state_in = ST_PLOT;
            mfde_pkg::OP_RECT: begin
               if (cmd_data.x_start > cmd_data.x_end ||
                   cmd_data.y_start > cmd_data.y_end ||
                   32'(cmd_data.x_start) >= Width ||
                   32'(cmd_data.y_start) >= Height) begin
                  state_in = ST_RSP;
               end else begin
                  state_in = ST_PLOT;
               end
            end
            mfde_pkg::OP_FILL: state_in = ST_FILL;
            mfde_pkg::OP_READ: state_in = ST_READ;
            default:           state_in = ST_RSP;
         endcase
      end
   end

   assign cmd_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      err_ff  <= err_in;
      last_ff <= last_in;
      if (cmd_valid && cmd_ready) begin
         op_ff    <= cmd_data.op;
         color_ff <= cmd_data.color;
         y0_ff    <= cmd_data.y_start;
         xe_ff    <= (cmd_data.op == mfde_pkg::OP_RECT && 32'(cmd_data.x_end) > Width - 1) ?
                     CB'(Width - 1) : cmd_data.x_end;
         ye_ff    <= (cmd_data.op == mfde_pkg::OP_RECT && 32'(cmd_data.y_end) > Height - 1) ?
                     CB'(Height - 1) : cmd_data.y_end;
         sx_ff    <= cmd_data.x_start < cmd_data.x_end;
         sy_ff    <= cmd_data.y_start < cmd_data.y_end;
         dx_ff    <= cmd_dx;
         dy_ff    <= cmd_dy;
         rmw_addr_ff <= AddrBits'(32'(cmd_data.x_start) * Pages
                                  + 32'(cmd_data.y_start[PageBits-1:0]));
      end else if (state_ff == ST_PLOT) begin
         rmw_addr_ff <= pix_addr;
         mask_ff     <= pix_mask;
      end
   end

   // Frame store: one read and one write port, registered read data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[(state_ff == ST_PLOT) ? pix_addr : rmw_addr_ff];
      if (state_ff == ST_CLEAR || state_ff == ST_FILL) begin
         mem[sweep_ff[AddrBits-1:0]] <= (state_ff == ST_FILL && color_ff) ? 8'hFF : 8'h00;
      end else if (state_ff == ST_RMW) begin
         mem[rmw_addr_ff] <= color_ff ? (rd_data_ff | mask_ff) : (rd_data_ff & ~mask_ff);
      end
   end

   // The read byte is registered in ST_READ and captured in the following ST_LATCH.
   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready) begin
         out_ff <= '0;
      end else if (state_ff == ST_LATCH) begin
         if (32'(x_ff) < Width && 32'(y_ff) < Pages) out_ff <= rd_data_ff;
      end
   end

   assign rsp.valid             = (state_ff == ST_RSP);
   assign rsp.payload.read_data = out_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> !rsp.valid) else $error("accept while responding");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(out_ff))
      else $error("response dropped");
   a_rmw_inrange: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLOT && !pix_in_range |=> state_ff != ST_RMW)
      else $error("clipped pixel written");

endmodule

FILE: rtl/mono_framebuffer_draw_engine_top.sv
// Top level of the monochrome framebuffer draw engine.
//
//   Channel  Dir  Handshake        Carries
//   req_     in   valid/ready      op, x_start, y_start, x_end, y_end, color
//   rsp_     out  valid/ready      read_data (zero except for a read)
//
// Reset is synchronous and clears the frame store (Width*Pages bytes, 1024 by
// default) with a sweep; commands queue but are not executed then.
// Each command leaves the queue and ends by presenting its response. Between
// those, each visible point of a pixel, line or rectangle is read, then
// written, and a clipped point is skipped; a fill sweeps every byte and a read
// fetches one byte. The frame store has one read and one write port. A
// two-entry command queue lets the requester keep posting while the back end
// works or waits on rsp_ready.
module mono_framebuffer_draw_engine_top #(
   parameter int Width  = mfde_pkg::DefWidth,
   parameter int Height = mfde_pkg::DefHeight
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  logic [7:0] req_x_start,
   input  logic [7:0] req_y_start,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic       req_color,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data
);

   mfde_req_if req ();
   mfde_rsp_if rsp ();

   logic              cmd_valid;
   logic              cmd_ready;
   mfde_pkg::cmd_type cmd_data;

   // Map the flat ports onto the channel interfaces.
   assign req.valid           = req_valid;
   assign req_ready           = req.ready;
   assign req.payload.op      = req_op;
   assign req.payload.x_start = req_x_start;
   assign req.payload.y_start = req_y_start;
   assign req.payload.x_end   = req_x_end;
   assign req.payload.y_end   = req_y_end;
   assign req.payload.color   = req_color;
   assign rsp_valid           = rsp.valid;
   assign rsp.ready           = rsp_ready;
   assign rsp_read_data       = rsp.payload.read_data;

   // Front end: accepts and classifies items into the command queue.
   mfde_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   // Back end: walks pixels and updates the frame store.
   mfde_back #(
      .Width  (Width),
      .Height (Height)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp       (rsp)
   );

endmodule

FILE: dv/mfde_tb_if.sv
// Testbench copies of the command and response valid/ready channel interfaces.
`timescale 1ns / 100ps
interface draw_cmd_chan (input logic clock);
   logic              valid;
   logic              ready;
   mfde_pkg::cmd_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface draw_rsp_chan (input logic clock);
   logic              valid;
   logic              ready;
   mfde_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: dv/tb.sv
// Self-checking testbench for the monochrome framebuffer draw engine top level.
`timescale 1ns / 100ps

// Shadow copy of the picture and the queue of response bytes it predicts.
class frame_scoreboard;
   localparam int NumPages = (mfde_pkg::DefHeight + 7) / 8;
   logic [7:0] pixels [mfde_pkg::DefWidth*NumPages];
   logic [7:0] read_queue [$];
   int         mismatches;

   function new();
      foreach (pixels[i]) pixels[i] = 8'h00;
      mismatches = 0;
   endfunction

   function void plot(int x, int y, logic color);
      int idx;
      logic [7:0] mask;
      if (x < 0 || y < 0 || x >= mfde_pkg::DefWidth || y >= mfde_pkg::DefHeight) return;
      idx  = x * NumPages + (NumPages - 1) - y / 8;
      mask = 8'h80 >> (y % 8);
      if (color) pixels[idx] |= mask;
      else       pixels[idx] &= ~mask;
   endfunction

   function void trace_line(int xa, int ya, int xb, int yb, logic color);
      int dx, dy, sx, sy, err, e2;
      dx  = (xb > xa) ? xb - xa : xa - xb;
      dy  = (yb > ya) ? yb - ya : ya - yb;
      sx  = (xa < xb) ? 1 : -1;
      sy  = (ya < yb) ? 1 : -1;
      err = dx - dy;
      plot(xb, yb, color);
      while (xa != xb || ya != yb) begin
         e2 = err * 2;
         plot(xa, ya, color);
         if (e2 > -dy) begin
            err -= dy;
            xa  += sx;
         end
         if (e2 < dx) begin
            err += dx;
            ya  += sy;
         end
      end
   endfunction

   // Notes one accepted command: applies it and queues the byte it returns.
   function void note_command(mfde_pkg::cmd_type c);
      logic [7:0] data;
      int xb, yb;
      data = 8'h00;
      case (c.op)
         mfde_pkg::OP_PIXEL: plot(c.x_start, c.y_start, c.color);
         mfde_pkg::OP_LINE:  trace_line(c.x_start, c.y_start, c.x_end, c.y_end, c.color);
         mfde_pkg::OP_RECT: begin
            xb = (c.x_end > mfde_pkg::DefWidth - 1) ? mfde_pkg::DefWidth - 1 : c.x_end;
            yb = (c.y_end > mfde_pkg::DefHeight - 1) ? mfde_pkg::DefHeight - 1 : c.y_end;
            for (int x = c.x_start; x <= xb; x++)
               for (int y = c.y_start; y <= yb; y++)
                  plot(x, y, c.color);
         end
         mfde_pkg::OP_FILL: foreach (pixels[i]) pixels[i] = c.color ? 8'hFF : 8'h00;
         mfde_pkg::OP_READ: begin
            if (c.x_start < mfde_pkg::DefWidth && c.y_start < NumPages)
               data = pixels[c.x_start * NumPages + c.y_start];
         end
         default: ;
      endcase
      read_queue.push_back(data);
   endfunction

   function void check_response(mfde_pkg::rsp_type r);
      logic [7:0] want;
      if (read_queue.size() == 0) begin
         report("response with nothing outstanding", r.read_data, 8'h00);
         return;
      end
      want = read_queue.pop_front();
      if (r.read_data !== want) report("read_data", r.read_data, want);
   endfunction

   function void report(string what, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH at %0t: %s got %02h expected %02h", $time, what, got, want);
      mismatches++;
   endfunction
endclass

module tb;
   localparam int WatchdogLimit = 40000;
   localparam int NumRandom     = 1630;

   logic clock = 1'b0;
   logic reset = 1'b1;

   draw_cmd_chan cmd_ch (clock);
   draw_rsp_chan rsp_ch (clock);

   frame_scoreboard board = new();

   // Idling is switched off for a long stretch in the middle of the random part.
   bit quiet_stretch = 1'b0;
   int idle_cycles   = 0;
   int commands_sent = 0;
   int responses_seen = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mono_framebuffer_draw_engine_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (cmd_ch.valid),
      .req_ready     (cmd_ch.ready),
      .req_op        (cmd_ch.payload.op),
      .req_x_start   (cmd_ch.payload.x_start),
      .req_y_start   (cmd_ch.payload.y_start),
      .req_x_end     (cmd_ch.payload.x_end),
      .req_y_end     (cmd_ch.payload.y_end),
      .req_color     (cmd_ch.payload.color),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_read_data (rsp_ch.payload.read_data)
   );

   initial begin
      cmd_ch.valid   = 1'b0;
      cmd_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
   end

   // The response side stalls with a probability of about 8 percent, except in the quiet stretch.
   // Accepted responses are checked here, on the edge where they are taken.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_response(rsp_ch.payload);
            responses_seen++;
         end
         rsp_ch.ready <= quiet_stretch || ($urandom_range(99) >= 8);
      end
   end

   // The watchdog counts cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (!reset) begin
         if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("mono_framebuffer_draw_engine_top test failed");
            $finish;
         end
      end
   end

   // Offers one command and holds it until it is accepted. Valid stays high
   // from one command to the next unless the sender chooses to idle.
   task automatic send_command(mfde_pkg::cmd_type c);
      while (!quiet_stretch && $urandom_range(99) < 8) begin
         cmd_ch.valid <= 1'b0;
         @(posedge clock);
      end
      cmd_ch.valid   <= 1'b1;
      cmd_ch.payload <= c;
      @(posedge clock);
      while (!cmd_ch.ready) @(posedge clock);
      board.note_command(c);
      commands_sent++;
   endtask

   task automatic send_fields(logic [2:0] op, int xs, int ys, int xe, int ye, logic color);
      mfde_pkg::cmd_type c;
      c.op      = op;
      c.x_start = xs[7:0];
      c.y_start = ys[7:0];
      c.x_end   = xe[7:0];
      c.y_end   = ye[7:0];
      c.color   = color;
      send_command(c);
   endtask

   // Most coordinates land on the screen or just past its edge; some use the full byte.
   function automatic logic [7:0] pick_x();
      int r;
      r = $urandom_range(99);
      if (r < 85) return 8'($urandom_range(mfde_pkg::DefWidth + 7));
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_y();
      int r;
      r = $urandom_range(99);
      if (r < 85) return 8'($urandom_range(mfde_pkg::DefHeight + 7));
      return 8'($urandom_range(255));
   endfunction

   task automatic send_random_command();
      mfde_pkg::cmd_type c;
      int r, x0, y0;
      r         = $urandom_range(99);
      c.color   = 1'($urandom_range(1));
      c.x_start = pick_x();
      c.y_start = pick_y();
      c.x_end   = pick_x();
      c.y_end   = pick_y();
      if (r < 25) begin
         c.op = mfde_pkg::OP_PIXEL;
      end else if (r < 45) begin
         c.op = mfde_pkg::OP_LINE;
      end else if (r < 57) begin
         // Rectangles are kept small so that runs stay short, a few reversed.
         c.op = mfde_pkg::OP_RECT;
         if ($urandom_range(9) != 0) begin
            x0 = c.x_start;
            y0 = c.y_start;
            c.x_end = 8'(x0 + $urandom_range(12));
            c.y_end = 8'(y0 + $urandom_range(10));
            if (c.x_end < x0) c.x_end = 8'hFF;
            if (c.y_end < y0) c.y_end = 8'hFF;
         end
      end else if (r < 59) begin
         c.op = mfde_pkg::OP_FILL;
      end else if (r < 95) begin
         // Reads mostly hit the picture; the page is usually in range.
         c.op      = mfde_pkg::OP_READ;
         c.x_start = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(mfde_pkg::DefWidth - 1));
         c.y_start = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(7));
      end else begin
         c.op = 3'($urandom_range(5, 7));
      end
      send_command(c);
   endtask

   initial begin
      int ticks;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every op, clipping at the right and bottom edges, reversed rectangles,
      // reads out of range, unused op codes and both fill colors.
      send_fields(mfde_pkg::OP_READ, 0, 0, 0, 0, 1'b0);
      send_fields(mfde_pkg::OP_PIXEL, 0, 0, 0, 0, 1'b1);
      send_fields(mfde_pkg::OP_PIXEL, 127, 63, 0, 0, 1'b1);
      send_fields(mfde_pkg::OP_PIXEL, 128, 10, 0, 0, 1'b1);
      send_fields(mfde_pkg::OP_PIXEL, 10, 64, 0, 0, 1'b1);
      send_fields(mfde_pkg::OP_PIXEL, 255, 255, 255, 255, 1'b1);
      send_fields(mfde_pkg::OP_READ, 0, 7, 0, 0, 1'b0);
      send_fields(mfde_pkg::OP_READ, 127, 0, 0, 0, 1'b0);
      send_fields(mfde_pkg::OP_LINE, 0, 0, 127, 63, 1'b1);
      send_fields(mfde_pkg::OP_LINE, 120, 60, 200, 90, 1'b1);
      send_fields(mfde_pkg::OP_LINE, 5, 40, 5, 40, 1'b1);
      send_fields(mfde_pkg::OP_LINE, 127, 0, 0, 63, 1'b0);
      send_fields(mfde_pkg::OP_RECT, 10, 10, 20, 17, 1'b1);
      send_fields(mfde_pkg::OP_RECT, 20, 10, 10, 17, 1'b1);
      send_fields(mfde_pkg::OP_RECT, 10, 17, 20, 10, 1'b1);
      send_fields(mfde_pkg::OP_RECT, 120, 56, 255, 255, 1'b1);
      send_fields(mfde_pkg::OP_READ, 15, 6, 0, 0, 1'b0);
      send_fields(mfde_pkg::OP_READ, 128, 0, 0, 0, 1'b0);
      send_fields(mfde_pkg::OP_READ, 0, 8, 0, 0, 1'b0);
      send_fields(mfde_pkg::OP_FILL, 0, 0, 0, 0, 1'b1);
      send_fields(mfde_pkg::OP_READ, 64, 3, 0, 0, 1'b0);
      send_fields(3'd5, 1, 1, 1, 1, 1'b0);
      send_fields(3'd6, 2, 2, 2, 2, 1'b1);
      send_fields(mfde_pkg::OP_NOP, 3, 3, 3, 3, 1'b0);
      send_fields(mfde_pkg::OP_FILL, 0, 0, 0, 0, 1'b0);

      for (int i = 0; i < NumRandom; i++) begin
         quiet_stretch = (i >= 600 && i < 900);
         send_random_command();
      end
      quiet_stretch = 1'b0;
      cmd_ch.valid <= 1'b0;

      ticks = 0;
      while (board.read_queue.size() != 0 && ticks < 200000) begin
         @(posedge clock);
         ticks++;
      end
      repeat (50) @(posedge clock);

      $display("Sent %0d commands (pixels, lines, rectangles, fills, reads, unused ops);",
               commands_sent);
      $display("checked %0d responses, %0d mismatches.", responses_seen, board.mismatches);
      if (board.mismatches == 0 && board.read_queue.size() == 0)
         $display("mono_framebuffer_draw_engine_top test passed");
      else
         $display("mono_framebuffer_draw_engine_top test failed");
      $finish;
   end
endmodule
